// ----- hdl/mcb_pkg.sv -----
`timescale 1ns / 1ps
package mcb_pkg;

  localparam logic [7:0] SIG_MID = 8'h4d;
  localparam logic [7:0] SIG_END = 8'h5a;

  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_ALLOC  = 3'd1;
  localparam logic [2:0] MODE_RESIZE = 3'd2;
  localparam logic [2:0] MODE_FREE   = 3'd3;
  localparam logic [2:0] MODE_MAX    = 3'd4;
  localparam logic [2:0] MODE_SIZE   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_BADSIG = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] block_segment;
    logic [15:0] min_paragraphs;
    logic [15:0] max_paragraphs;
    logic [7:0]  header_signature;
    logic [15:0] header_owner;
    logic [15:0] header_count;
  } mcb_req_t;

  typedef struct packed {
    logic [15:0] result_segment;
    logic [15:0] result_size;
    logic [1:0]  status;
  } mcb_rsp_t;

  typedef struct packed {
    logic [7:0]  sig;
    logic [15:0] own;
    logic [15:0] cnt;
  } mcb_hdr_t;

  // memory port request from the sequencer
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [15:0] addr;
    mcb_hdr_t    wdata;
  } mcb_mem_req_t;

  function automatic logic sig_ok(input logic [7:0] s);
    sig_ok = (s == SIG_MID) || (s == SIG_END);
  endfunction

endpackage

// ----- hdl/mcb_store.sv -----
`timescale 1ns / 1ps
// Header store: one port, registered read. Out-of-range segments read as zero
// and ignore writes. A clearing pass zeroes the store after reset.
module mcb_store #(
  parameter int STORE_SEGMENTS = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  mcb_pkg::mcb_mem_req_t mreq,
  output mcb_pkg::mcb_hdr_t    rdata,
  output logic                 clr_busy
);
  import mcb_pkg::*;

  localparam int AW = (STORE_SEGMENTS > 1) ? $clog2(STORE_SEGMENTS) : 1;

  mcb_hdr_t mem [STORE_SEGMENTS];
  logic [AW:0] clr_ptr;
  logic        in_range;
  logic        rd_in_range;
  mcb_hdr_t    rd_raw;

  assign in_range = ({16'd0, mreq.addr} < 32'(STORE_SEGMENTS));
  assign clr_busy = (clr_ptr < (AW+1)'(STORE_SEGMENTS));

  // clearing sweep pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ptr <= '0;
    end else if (clr_busy) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // write and registered read
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_ptr[AW-1:0]] <= '0;
    end else if (mreq.wr && in_range) begin
      mem[mreq.addr[AW-1:0]] <= mreq.wdata;
    end
    if (mreq.rd) begin
      rd_raw      <= mem[mreq.addr[AW-1:0]];
      rd_in_range <= in_range;
    end
  end

  assign rdata = rd_in_range ? rd_raw : '0;

endmodule

// ----- hdl/mcb_seq.sv -----
`timescale 1ns / 1ps
// Sequencer: drives the store port one access per step and computes splits.
module mcb_seq #(
  parameter int WALK_LIMIT = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [15:0]           chain_start,
  input  logic                  start,
  input  mcb_pkg::mcb_req_t     req,
  input  mcb_pkg::mcb_hdr_t     rdata,
  output mcb_pkg::mcb_mem_req_t mreq,
  output logic                  done,
  output mcb_pkg::mcb_rsp_t     rsp
);
  import mcb_pkg::*;

  localparam int WW = $clog2(WALK_LIMIT + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD1   = 9'b000000010,
    S_EVAL1 = 9'b000000100,
    S_RD2   = 9'b000001000,
    S_EVAL2 = 9'b000010000,
    S_WR1   = 9'b000100000,
    S_WR2   = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_WAIT  = 9'b100000000
  } state_t;

  state_t      state, state_next;
  mcb_req_t    r;
  logic [15:0] seg, best;
  logic [WW-1:0] steps;
  mcb_hdr_t    h1;
  logic [15:0] seg2;
  mcb_hdr_t    w1, w2;
  logic        do_w2;
  mcb_rsp_t    res;

  // combinational helpers
  logic [15:0] pick;
  logic [16:0] mcnt;
  logic        merge_ok;

  assign pick     = (r.max_paragraphs < rdata.cnt) ? r.max_paragraphs : rdata.cnt;
  assign mcnt     = {1'b0, h1.cnt} + {1'b0, rdata.cnt} + 17'd1;
  assign merge_ok = (rdata.own == 16'd0) && !mcnt[16];

  // memory port
  always_comb begin
    mreq = '0;
    case (state)
      S_RD1: begin
        mreq.rd   = 1'b1;
        mreq.addr = seg;
      end
      S_RD2: begin
        mreq.rd   = 1'b1;
        mreq.addr = seg2;
      end
      S_WR1: begin
        mreq.wr    = 1'b1;
        mreq.addr  = seg;
        mreq.wdata = w1;
      end
      S_WR2: begin
        mreq.wr    = 1'b1;
        mreq.addr  = seg2;
        mreq.wdata = w2;
      end
      default: ;
    endcase
  end

  assign done = (state == S_DONE);
  assign rsp  = res;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          r     <= req;
          res   <= '0;
          best  <= '0;
          steps <= '0;
          do_w2 <= 1'b0;
          if (req.mode == MODE_ALLOC || req.mode == MODE_MAX) begin
            seg <= chain_start;
          end else if (req.mode == MODE_WRITE) begin
            seg <= req.block_segment;
            w1  <= '{req.header_signature, req.header_owner, req.header_count};
          end else begin
            seg <= req.block_segment - 16'd1;
          end
        end
      end
      S_RD1: begin
        steps <= steps + 1'b1;
      end
      S_EVAL1: begin
        h1 <= rdata;
        if (r.mode == MODE_SIZE) begin
          res.result_size <= rdata.cnt;
        end else if (!sig_ok(rdata.sig)) begin
          res.status <= ST_BADSIG;
        end else if (r.mode == MODE_ALLOC) begin
          if (rdata.own == 16'd0 && rdata.cnt >= r.min_paragraphs) begin
            res.result_segment <= seg + 16'd1;
            if (rdata.cnt - pick > 16'd1) begin
              do_w2 <= 1'b1;
              seg2  <= seg + pick + 16'd1;
              w2    <= '{rdata.sig, 16'd0, rdata.cnt - pick - 16'd1};
              w1    <= '{SIG_MID, seg + 16'd1, pick};
            end else begin
              w1    <= '{rdata.sig, seg + 16'd1, rdata.cnt};
            end
          end else if (rdata.sig != SIG_MID) begin
            res.status <= ST_NOFIT;
          end else if ({{(32-WW){1'b0}}, steps} >= 32'(WALK_LIMIT)) begin
            res.status <= ST_LIMIT;
          end else begin
            seg <= seg + rdata.cnt + 16'd1;
          end
        end else if (r.mode == MODE_MAX) begin
          if (rdata.own == 16'd0 && rdata.cnt > best) begin
            best <= rdata.cnt;
          end
          if (rdata.sig != SIG_MID) begin
            res.result_size <= (rdata.own == 16'd0 && rdata.cnt > best) ? rdata.cnt : best;
          end else if ({{(32-WW){1'b0}}, steps} >= 32'(WALK_LIMIT)) begin
            res.status <= ST_LIMIT;
          end else begin
            seg <= seg + rdata.cnt + 16'd1;
          end
        end else begin
          // resize and free: successor header address
          seg2 <= seg + rdata.cnt + 16'd1;
        end
      end
      S_EVAL2: begin
        // h1 is the block, rdata its successor (rdata unused when h1 is the last block)
        if (h1.sig == SIG_MID && !sig_ok(rdata.sig)) begin
          res.status <= ST_BADSIG;
          if (r.mode == MODE_FREE) begin
            w1 <= '{h1.sig, 16'd0, h1.cnt};
          end
        end else if (r.mode == MODE_FREE) begin
          if (h1.sig == SIG_MID && merge_ok) begin
            w1 <= '{rdata.sig, 16'd0, mcnt[15:0]};
          end else begin
            w1 <= '{h1.sig, 16'd0, h1.cnt};
          end
        end else begin
          // resize: merged size and signature
          if (h1.sig == SIG_MID && merge_ok) begin
            if ({1'b0, r.max_paragraphs} > mcnt) begin
              res.status <= ST_NOFIT;
            end else begin
              res.result_segment <= seg + 16'd1;
              h1 <= '{rdata.sig, h1.own, mcnt[15:0]};
            end
          end else if (r.max_paragraphs > h1.cnt) begin
            res.status <= ST_NOFIT;
          end else begin
            res.result_segment <= seg + 16'd1;
          end
        end
      end
      S_WAIT: begin
        // resize split using the adjusted header
        if (h1.cnt - r.max_paragraphs > 16'd1) begin
          do_w2 <= 1'b1;
          seg2  <= seg + r.max_paragraphs + 16'd1;
          w2    <= '{h1.sig, 16'd0, h1.cnt - r.max_paragraphs - 16'd1};
          w1    <= '{SIG_MID, h1.own, r.max_paragraphs};
        end else begin
          w1    <= '{h1.sig, h1.own, r.max_paragraphs};
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (req.mode == MODE_WRITE) begin
            state_next = S_WR1;
          end else if (req.mode > MODE_SIZE) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD1;
          end
        end
      end
      S_RD1:   state_next = S_EVAL1;
      S_EVAL1: begin
        if (r.mode == MODE_SIZE || !sig_ok(rdata.sig)) begin
          state_next = S_DONE;
        end else if (r.mode == MODE_ALLOC) begin
          if (rdata.own == 16'd0 && rdata.cnt >= r.min_paragraphs) begin
            state_next = S_WR1;
          end else if (rdata.sig != SIG_MID ||
                       {{(32-WW){1'b0}}, steps} >= 32'(WALK_LIMIT)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD1;
          end
        end else if (r.mode == MODE_MAX) begin
          if (rdata.sig != SIG_MID ||
              {{(32-WW){1'b0}}, steps} >= 32'(WALK_LIMIT)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_RD1;
          end
        end else if (rdata.sig == SIG_MID) begin
          state_next = S_RD2;
        end else begin
          state_next = S_EVAL2;
        end
      end
      S_RD2:   state_next = S_EVAL2;
      S_EVAL2: begin
        if (h1.sig == SIG_MID && !sig_ok(rdata.sig)) begin
          state_next = (r.mode == MODE_FREE) ? S_WR1 : S_DONE;
        end else if (r.mode == MODE_FREE) begin
          state_next = S_WR1;
        end else if (h1.sig == SIG_MID && merge_ok) begin
          state_next = ({1'b0, r.max_paragraphs} > mcnt) ? S_DONE : S_WAIT;
        end else begin
          state_next = (r.max_paragraphs > h1.cnt) ? S_DONE : S_WAIT;
        end
      end
      S_WAIT:  state_next = S_WR1;
      S_WR1:   state_next = do_w2 ? S_WR2 : S_DONE;
      S_WR2:   state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- hdl/mcb_chain_allocator_top.sv -----
`timescale 1ns / 1ps
// Alloc and get_max do one store read per header walked; unused modes answer
// without touching the store.
// One request at a time: the next is taken only after the response is accepted.
// Reset: synchronous; chain_start clears, then a clearing pass zeroes every store
// segment, during which no request is taken.
module mcb_chain_allocator_top #(
  parameter int STORE_SEGMENTS = 4096,
  parameter int WALK_LIMIT     = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcb_pkg::mcb_req_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mcb_pkg::mcb_rsp_t out_data
);
  import mcb_pkg::*;

  logic [15:0]  chain_start;
  logic         clr_busy, busy, done, start;
  mcb_mem_req_t mreq;
  mcb_hdr_t     rdata;
  mcb_rsp_t     rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_start <= '0;
    end else if (cfg_we) begin
      chain_start <= cfg_wdata;
    end
  end

  assign in_ready = !busy && !clr_busy && !out_valid;
  assign start    = in_valid && in_ready;

  // busy from accept to result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= rsp;
    end
  end

  mcb_store #(.STORE_SEGMENTS(STORE_SEGMENTS)) u_store (
    .clk(clk), .rst(rst), .mreq(mreq), .rdata(rdata), .clr_busy(clr_busy)
  );

  mcb_seq #(.WALK_LIMIT(WALK_LIMIT)) u_seq (
    .clk(clk), .rst(rst), .chain_start(chain_start), .start(start), .req(in_data),
    .rdata(rdata), .mreq(mreq), .done(done), .rsp(rsp)
  );

endmodule
